@@ rtl/assert_macros.svh @@
// Assertion macros shared by the vending change controller RTL.
// Needs a clock named clk and a synchronous reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define VCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define VCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  `VCC_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

@@ rtl/vcc_pkg.sv @@
// Package for the vending change controller: beat types, codes, constants.
// Greedy change helpers live here too. No dependencies.
package vcc_pkg;

  localparam int NUM_PRODUCTS = 6;
  localparam int NUM_PRICES   = 6;
  localparam int NUM_DENOMS   = 8;
  localparam int DEN_AW       = 3;
  localparam int PROD_AW      = (NUM_PRODUCTS > 1) ? $clog2(NUM_PRODUCTS) : 1;
  localparam int CENT_W       = 11;
  localparam int COIN_W       = 10;
  localparam int SES_W        = 9;
  localparam int NEXT_W       = 12;
  localparam int TOTAL_W      = 24;
  localparam int PADDR_W      = 5;

  localparam logic [COIN_W-1:0] COIN_MAX = '1;
  localparam logic [SES_W-1:0]  SES_MAX  = '1;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_PRICE_LAST = 3'd5;
  localparam logic [2:0] REG_LIMIT      = 3'd6;

  typedef enum logic [1:0] {
    FN_INSERT   = 2'd0,
    FN_SELECT   = 2'd1,
    FN_SET_COIN = 2'd2,
    FN_SET_PROD = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    STS_ACCEPTED  = 3'd0,
    STS_OVER      = 3'd1,
    STS_SOLD      = 3'd2,
    STS_NO_CREDIT = 3'd3,
    STS_NO_CHANGE = 3'd4,
    STS_NOT_FOUND = 3'd5,
    STS_RESTOCKED = 3'd6,
    STS_CLOSED    = 3'd7
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HOLD,
    S_INS_WR,
    S_COIN_WR,
    S_SEL_PS,
    S_GIVE,
    S_CHK_RD,
    S_CHK_EV,
    S_DECIDE,
    S_CM_RD,
    S_CM_WR
  } state_e;

  typedef struct packed {
    logic [1:0] func;
    logic [2:0] denomination;
    logic [2:0] product_index;
    logic [9:0] stock_count;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [10:0] credit_cents;
    logic [2:0]  change_denomination;
    logic [2:0]  change_count;
    logic        last;
  } result_t;

  // Face value of a denomination code in cents
  function automatic logic [CENT_W-1:0] denom_cents(input logic [DEN_AW-1:0] d);
    logic [CENT_W-1:0] v;
    case (d)
      3'd0:    v = 11'd5;
      3'd1:    v = 11'd10;
      3'd2:    v = 11'd25;
      3'd3:    v = 11'd50;
      3'd4:    v = 11'd100;
      3'd5:    v = 11'd500;
      3'd6:    v = 11'd1000;
      default: v = 11'd2000;
    endcase
    return v;
  endfunction

  // Pieces of one denomination for the remaining change; never above four
  function automatic logic [2:0] greedy_give(input logic [CENT_W-1:0] rest,
                                             input logic [DEN_AW-1:0] d);
    logic [13:0] den;
    logic [2:0]  g;
    den = {3'b000, denom_cents(d)};
    g   = '0;
    for (int k = 1; k <= 4; k++) begin
      if ({3'b000, rest} >= 14'(k) * den) g = 3'(k);
    end
    return g;
  endfunction

  // Single result beat with no change fields
  function automatic result_t single_res(input status_e s, input logic [CENT_W-1:0] c);
    result_t r;
    r.status              = s;
    r.credit_cents        = c;
    r.change_denomination = '0;
    r.change_count        = '0;
    r.last                = 1'b1;
    return r;
  endfunction

endpackage

@@ rtl/vcc_regs.sv @@
// Configuration registers of the vending change controller: prices and limit.
// APB-style slave, always ready. Depends on vcc_pkg.
module vcc_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [vcc_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output logic [vcc_pkg::NUM_PRICES-1:0][vcc_pkg::CENT_W-1:0] price,
  output logic [vcc_pkg::CENT_W-1:0]   credit_limit
);
  import vcc_pkg::*;

  logic [2:0] idx;
  logic       wr;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;

  // Write a register at the access beat
  always_ff @(posedge clk) begin
    if (rst) begin
      price[0]     <= 11'd25;
      price[1]     <= 11'd35;
      price[2]     <= 11'd50;
      price[3]     <= 11'd100;
      price[4]     <= 11'd150;
      price[5]     <= 11'd0;
      credit_limit <= 11'd2000;
    end else if (wr) begin
      if (idx <= REG_PRICE_LAST) begin
        price[idx] <= pwdata[CENT_W-1:0];
      end else if (idx == REG_LIMIT) begin
        credit_limit <= pwdata[CENT_W-1:0];
      end
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    if (idx <= REG_PRICE_LAST) begin
      prdata = {21'b0, price[idx]};
    end else if (idx == REG_LIMIT) begin
      prdata = {21'b0, credit_limit};
    end
  end

endmodule

@@ rtl/vending_change_controller_core.sv @@
// Vending change controller: coin credit, product sale and greedy change.
// Depends on vcc_pkg, vcc_regs and assert_macros.svh.
//
// Use: raise start with an item beat while busy is low; the beat is taken at
// that edge and busy rises at once. Results come out on result with
// result_valid high for exactly one cycle each; result.last marks the final
// beat of an item. The receiver cannot stall, so nothing is held back.
// Insert and set-coin items read the coin memory, then write the updated word
// and register their result. Refused inserts, product restock and unknown
// products register their result at once and pass through a hold state. A
// selection reads the product stock, forms change one denomination a cycle,
// checks the new inventory with one read of the coin memory per denomination,
// then, on a sale, commits and emits its eight change beats. The coin memory
// port sets that pace: one read-modify-write per denomination. Prices and the
// credit limit sit on the APB port; the user must write them only when idle,
// as the block does not enforce it. Reset clears credit, session and stock
// valid bits, so all counts read zero; no clearing pass is needed.
module vending_change_controller_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  vcc_pkg::item_t               item,
  output vcc_pkg::result_t             result,
  output logic                         result_valid,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [vcc_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import vcc_pkg::*;

  `include "assert_macros.svh"

  localparam int WORD_W = COIN_W + SES_W;

  logic [NUM_PRICES-1:0][CENT_W-1:0] price;
  logic [CENT_W-1:0]                 credit_limit;

  vcc_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .price        (price),
    .credit_limit (credit_limit)
  );

  // Control registers
  state_e              state, state_next;
  logic [DEN_AW-1:0]   cnt, cnt_next;
  logic [CENT_W-1:0]   credit, credit_next;
  logic                closed, closed_next;
  item_t               op, op_next;
  logic [CENT_W-1:0]   rest, rest_next;
  logic [2:0]          give [NUM_DENOMS];
  logic [2:0]          give_next [NUM_DENOMS];
  logic signed [TOTAL_W-1:0] total, total_next;
  logic                bad, bad_next;
  result_t             res, res_next;
  logic                res_valid, res_valid_next;

  // Coin memory: {coin count, session count} per denomination
  logic [WORD_W-1:0]     cs_mem [NUM_DENOMS];
  logic [WORD_W-1:0]     cs_q;
  logic                  coin_v_q, ses_v_q;
  logic [NUM_DENOMS-1:0] coin_vld, ses_vld;
  logic                  rd_en, wr_en, ses_clr;
  logic [DEN_AW-1:0]     rd_addr, wr_addr;
  logic [WORD_W-1:0]     wr_data;

  // Product stock memory
  logic [COIN_W-1:0]       prod_mem [NUM_PRODUCTS];
  logic [COIN_W-1:0]       prod_q;
  logic                    prod_v_q;
  logic [NUM_PRODUCTS-1:0] prod_vld;
  logic                    prod_rd_en, prod_wr_en;
  logic [PROD_AW-1:0]      prod_rd_addr, prod_wr_addr;
  logic [COIN_W-1:0]       prod_wr_data;

  // Datapath helpers
  logic [COIN_W-1:0]        coin_eff, stock_eff;
  logic [SES_W-1:0]         ses_eff;
  logic signed [NEXT_W-1:0] nxt;
  logic [COIN_W-1:0]        nxt_sat;
  logic [CENT_W-1:0]        den_c, price_sel;
  logic [CENT_W:0]          ins_sum;
  logic [2:0]               g;
  logic signed [TOTAL_W-1:0] val_d;

  assign coin_eff  = coin_v_q ? cs_q[WORD_W-1:SES_W] : '0;
  assign ses_eff   = ses_v_q ? cs_q[SES_W-1:0] : '0;
  assign stock_eff = prod_v_q ? prod_q : '0;
  assign nxt       = $signed({2'b00, coin_eff}) + $signed({3'b000, ses_eff})
                     - $signed({9'b0, give[cnt]});
  assign nxt_sat   = (nxt > $signed({2'b00, COIN_MAX})) ? COIN_MAX : nxt[COIN_W-1:0];
  assign den_c     = denom_cents(cnt);
  assign val_d     = TOTAL_W'(nxt) * $signed({13'b0, den_c});
  assign price_sel = (op.product_index < 3'(NUM_PRODUCTS)) ? price[op.product_index] : '0;
  assign ins_sum   = {1'b0, credit} + {1'b0, denom_cents(item.denomination)};
  assign g         = greedy_give(rest, cnt);

  assign busy         = (state != S_IDLE);
  assign result       = res;
  assign result_valid = res_valid;

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      credit    <= '0;
      closed    <= 1'b0;
      res_valid <= 1'b0;
      bad       <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      credit    <= credit_next;
      closed    <= closed_next;
      res_valid <= res_valid_next;
      bad       <= bad_next;
    end
  end

  // Hold payload
  always_ff @(posedge clk) begin
    op    <= op_next;
    rest  <= rest_next;
    give  <= give_next;
    total <= total_next;
    res   <= res_next;
  end

  // Coin memory with registered read
  always_ff @(posedge clk) begin
    if (wr_en) cs_mem[wr_addr] <= wr_data;
    if (rd_en) cs_q <= cs_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coin_vld <= '0;
      ses_vld  <= '0;
      coin_v_q <= 1'b0;
      ses_v_q  <= 1'b0;
    end else begin
      if (rd_en) begin
        coin_v_q <= coin_vld[rd_addr];
        ses_v_q  <= ses_vld[rd_addr];
      end
      if (wr_en) coin_vld[wr_addr] <= 1'b1;
      // Drop the whole session at once; a write in that cycle carries no session count
      if (ses_clr) begin
        ses_vld <= '0;
      end else if (wr_en) begin
        ses_vld[wr_addr] <= 1'b1;
      end
    end
  end

  // Product memory with registered read
  always_ff @(posedge clk) begin
    if (prod_wr_en) prod_mem[prod_wr_addr] <= prod_wr_data;
    if (prod_rd_en) prod_q <= prod_mem[prod_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= '0;
      prod_v_q <= 1'b0;
    end else begin
      if (prod_rd_en) prod_v_q <= prod_vld[prod_rd_addr];
      if (prod_wr_en) prod_vld[prod_wr_addr] <= 1'b1;
    end
  end

  // Next state, memory commands and result beats
  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    credit_next    = credit;
    closed_next    = closed;
    op_next        = op;
    rest_next      = rest;
    give_next      = give;
    total_next     = total;
    bad_next       = bad;
    res_next       = res;
    res_valid_next = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = cnt;
    wr_en          = 1'b0;
    wr_addr        = cnt;
    wr_data        = {coin_eff, ses_eff};
    ses_clr        = 1'b0;
    prod_rd_en     = 1'b0;
    prod_rd_addr   = item.product_index[PROD_AW-1:0];
    prod_wr_en     = 1'b0;
    prod_wr_addr   = item.product_index[PROD_AW-1:0];
    prod_wr_data   = item.stock_count;

    case (state)
      S_IDLE: begin
        if (start) begin
          op_next = item;
          case (func_e'(item.func))
            FN_INSERT: begin
              if (closed) begin
                res_next       = single_res(STS_CLOSED, credit);
                res_valid_next = 1'b1;
                state_next     = S_HOLD;
              end else if (ins_sum > {1'b0, credit_limit}) begin
                closed_next    = 1'b1;
                res_next       = single_res(STS_OVER, credit);
                res_valid_next = 1'b1;
                state_next     = S_HOLD;
              end else begin
                credit_next = ins_sum[CENT_W-1:0];
                if (item.denomination == 3'(NUM_DENOMS - 1)) closed_next = 1'b1;
                rd_en      = 1'b1;
                rd_addr    = item.denomination;
                state_next = S_INS_WR;
              end
            end
            FN_SELECT: begin
              if (item.product_index >= 3'(NUM_PRODUCTS)) begin
                credit_next    = '0;
                closed_next    = 1'b0;
                ses_clr        = 1'b1;
                res_next       = single_res(STS_NOT_FOUND, '0);
                res_valid_next = 1'b1;
                state_next     = S_HOLD;
              end else begin
                prod_rd_en = 1'b1;
                state_next = S_SEL_PS;
              end
            end
            FN_SET_COIN: begin
              rd_en      = 1'b1;
              rd_addr    = item.denomination;
              state_next = S_COIN_WR;
            end
            default: begin
              if (item.product_index >= 3'(NUM_PRODUCTS)) begin
                res_next = single_res(STS_NOT_FOUND, credit);
              end else begin
                prod_wr_en = 1'b1;
                res_next   = single_res(STS_RESTOCKED, credit);
              end
              res_valid_next = 1'b1;
              state_next     = S_HOLD;
            end
          endcase
        end
      end

      S_HOLD: state_next = S_IDLE;

      // Bump the session count of the inserted piece
      S_INS_WR: begin
        wr_en          = 1'b1;
        wr_addr        = op.denomination;
        wr_data        = {coin_eff, (ses_eff == SES_MAX) ? ses_eff : ses_eff + 1'b1};
        res_next       = single_res(STS_ACCEPTED, credit);
        res_valid_next = 1'b1;
        state_next     = S_IDLE;
      end

      S_COIN_WR: begin
        wr_en          = 1'b1;
        wr_addr        = op.denomination;
        wr_data        = {op.stock_count, ses_eff};
        res_next       = single_res(STS_RESTOCKED, credit);
        res_valid_next = 1'b1;
        state_next     = S_IDLE;
      end

      // Check stock and credit
      S_SEL_PS: begin
        if (stock_eff == '0 || credit < price_sel) begin
          credit_next    = '0;
          closed_next    = 1'b0;
          ses_clr        = 1'b1;
          res_next       = single_res(STS_NO_CREDIT, '0);
          res_valid_next = 1'b1;
          state_next     = S_IDLE;
        end else begin
          rest_next  = credit - price_sel;
          cnt_next   = 3'(NUM_DENOMS - 1);
          total_next = '0;
          bad_next   = 1'b0;
          state_next = S_GIVE;
        end
      end

      // Greedy change, largest denomination first
      S_GIVE: begin
        give_next[cnt] = g;
        rest_next      = rest - CENT_W'(14'(g) * {3'b000, den_c});
        if (cnt == '0) begin
          state_next = S_CHK_RD;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end

      S_CHK_RD: begin
        rd_en      = 1'b1;
        state_next = S_CHK_EV;
      end

      // Accumulate new inventory value and flag denominations left empty (the largest only when below zero)
      S_CHK_EV: begin
        total_next = total + val_d;
        if ((cnt == 3'(NUM_DENOMS - 1)) ? (nxt < 0) : (nxt <= 0)) bad_next = 1'b1;
        if (cnt == 3'(NUM_DENOMS - 1)) begin
          state_next = S_DECIDE;
        end else begin
          cnt_next   = cnt + 1'b1;
          state_next = S_CHK_RD;
        end
      end

      S_DECIDE: begin
        credit_next = '0;
        closed_next = 1'b0;
        if (bad || total <= 0) begin
          ses_clr        = 1'b1;
          res_next       = single_res(STS_NO_CHANGE, '0);
          res_valid_next = 1'b1;
          state_next     = S_IDLE;
        end else begin
          prod_wr_en   = 1'b1;
          prod_wr_addr = op.product_index[PROD_AW-1:0];
          prod_wr_data = stock_eff - 1'b1;
          cnt_next     = '0;
          state_next   = S_CM_RD;
        end
      end

      S_CM_RD: begin
        rd_en      = 1'b1;
        state_next = S_CM_WR;
      end

      // Commit one denomination and emit its change beat
      S_CM_WR: begin
        wr_en                        = 1'b1;
        wr_data                      = {nxt_sat, {SES_W{1'b0}}};
        res_next.status              = STS_SOLD;
        res_next.credit_cents        = '0;
        res_next.change_denomination = cnt;
        res_next.change_count        = give[cnt];
        res_next.last                = (cnt == 3'(NUM_DENOMS - 1));
        res_valid_next               = 1'b1;
        if (cnt == 3'(NUM_DENOMS - 1)) begin
          ses_clr    = 1'b1;
          state_next = S_IDLE;
        end else begin
          cnt_next   = cnt + 1'b1;
          state_next = S_CM_RD;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  `VCC_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
  `VCC_ASSERT(a_commit_ok, (state == S_CM_WR) |-> (!bad && total > 0), "commit of bad sale")
  `VCC_ASSERT(a_sold_clears, (result_valid && result.status == STS_SOLD && result.last) |-> (ses_vld == '0), "session kept after sale")

endmodule
